FILE: hw/rtl/stv_pkg.sv
package stv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LOG_FRAC  = 24;
	localparam int ROOT_STEPS = 32;
	localparam int DIV_BITS  = 32 + FRAC_BITS;
	localparam int RATE_INT  = 16;
	localparam int KM_SHIFT  = 31 + FRAC_BITS;
	localparam logic [62:0] TERM_CAP = 63'd1 << 60;

	// stage numbering after the rate register
	localparam int LG_END  = LOG_FRAC;
	localparam int MUL_STG = LG_END + 1;
	localparam int XT_STG  = MUL_STG + 1;
	localparam int X_END   = XT_STG + LOG_FRAC;
	localparam int K_STG   = X_END + 1;
	localparam int T_STG   = K_STG + 1;

	typedef enum logic [2:0] {
		REG_DIMENSIONS   = 3'd0,
		REG_POWER_MODE   = 3'd1,
		REG_PLATEAU      = 3'd2,
		REG_CRIT_RATE    = 3'd3,
		REG_CONSISTENCY  = 3'd4,
		REG_FLOW_INDEX   = 3'd5,
		REG_YIELD_OFFSET = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic sat;
		logic plat;
		logic neg;
	} ctl_t;

	function automatic logic [31:0] abs32(input logic [31:0] g);
		return g[31] ? (~g + 32'd1) : g;
	endfunction

	function automatic logic [32:0] abs_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		return s[32] ? (~s + 33'd1) : s;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] bitv;
		logic [63:0] x;
		r = '0;
		x = v;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (x >= r + bitv) begin
				x = x - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	// 2^(2^-i) in Q1.31, truncated square roots from 2
	function automatic logic [31:0] exp_coef(input int i);
		logic [63:0] c;
		c = 64'd1 << 32;
		for (int j = 1; j <= i; j++) begin
			c = isqrt64(c << 31);
		end
		return c[31:0];
	endfunction

endpackage

FILE: hw/rtl/shear_thinning_viscosity.sv
// channel   direction  strobe / condition      payload
// item      in         start && !busy          grad_xx .. grad_zz
// config    in         cfg_we                  cfg_index, cfg_data
// result    out        done                    particle_viscosity, saturated
//
// One beat enters per cycle; busy is always low.
// The datapath runs through the 32-step square root, the 24-step log2 and
// 24-step exp2 chains (one 32x32 multiply per log2/exp2 stage) plus the k multiply.
// The quotient |yield_offset| / rate runs as a 48-stage divider beside the log/exp chain.
// Reset clears valid bits and registers to their defaults; results are one-cycle strobes.
// No stalls: the receiver cannot hold results off, so the pipeline never stops.
module shear_thinning_viscosity (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] grad_xx,
	input  logic signed [31:0] grad_xy,
	input  logic signed [31:0] grad_xz,
	input  logic signed [31:0] grad_yx,
	input  logic signed [31:0] grad_yy,
	input  logic signed [31:0] grad_yz,
	input  logic signed [31:0] grad_zx,
	input  logic signed [31:0] grad_zy,
	input  logic signed [31:0] grad_zz,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] particle_viscosity,
	output logic               saturated
);
	import stv_pkg::*;

	logic [1:0]  dim_q;
	logic        pmode_q;
	logic [30:0] plateau_q;
	logic [30:0] crit_q;
	logic [30:0] coef_q;
	logic [20:0] flow_q;
	logic [31:0] yield_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q     <= 2'd3;
			pmode_q   <= 1'b0;
			plateau_q <= 31'd65536;
			crit_q    <= 31'd65536;
			coef_q    <= 31'd65536;
			flow_q    <= 21'd65536;
			yield_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DIMENSIONS:   dim_q     <= cfg_data[1:0];
				REG_POWER_MODE:   pmode_q   <= cfg_data[0];
				REG_PLATEAU:      plateau_q <= cfg_data[30:0];
				REG_CRIT_RATE:    crit_q    <= cfg_data[30:0];
				REG_CONSISTENCY:  coef_q    <= cfg_data[30:0];
				REG_FLOW_INDEX:   flow_q    <= cfg_data[20:0];
				REG_YIELD_OFFSET: yield_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// ---- squares
	logic        is2d;
	logic [31:0] a_xx, a_yy, a_zz;
	logic [32:0] a_xy, a_xz, a_yz;
	logic [63:0] m_xx, m_yy, m_zz;
	logic [65:0] m_xy, m_xz, m_yz;
	logic [64:0] t_s1 [0:5];
	ctl_t        ctl_s1;

	assign is2d = (dim_q == 2'd2);
	assign a_xx = abs32(grad_xx);
	assign a_yy = abs32(grad_yy);
	assign a_zz = abs32(grad_zz);
	assign a_xy = abs_sum(grad_xy, grad_yx);
	assign a_xz = abs_sum(grad_xz, grad_zx);
	assign a_yz = abs_sum(grad_yz, grad_zy);
	assign m_xx = a_xx * a_xx;
	assign m_yy = a_yy * a_yy;
	assign m_zz = a_zz * a_zz;
	assign m_xy = a_xy * a_xy;
	assign m_xz = a_xz * a_xz;
	assign m_yz = a_yz * a_yz;

	always_ff @(posedge clk) begin
		t_s1[0] <= {1'b0, m_xx[62:0], 1'b0};
		t_s1[1] <= {1'b0, m_yy[62:0], 1'b0};
		t_s1[2] <= is2d ? 65'd0 : {1'b0, m_zz[62:0], 1'b0};
		t_s1[3] <= m_xy[64:0];
		t_s1[4] <= is2d ? 65'd0 : m_xz[64:0];
		t_s1[5] <= is2d ? 65'd0 : m_yz[64:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '{valid: start, sat: 1'b0, plat: 1'b0, neg: 1'b0};
		end
	end

	// ---- sum
	logic [65:0] p_s2 [0:2];
	ctl_t        ctl_s2;
	logic [66:0] total;

	always_ff @(posedge clk) begin
		p_s2[0] <= {1'b0, t_s1[0]} + {1'b0, t_s1[1]};
		p_s2[1] <= {1'b0, t_s1[2]} + {1'b0, t_s1[3]};
		p_s2[2] <= {1'b0, t_s1[4]} + {1'b0, t_s1[5]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	assign total = {1'b0, p_s2[0]} + {1'b0, p_s2[1]} + {1'b0, p_s2[2]};

	// ---- square root, one result bit per stage
	logic [34:0] rt_rem_s  [0:ROOT_STEPS];
	logic [31:0] rt_root_s [0:ROOT_STEPS];
	logic [63:0] rt_val_s  [0:ROOT_STEPS];
	ctl_t        rt_ctl_s  [0:ROOT_STEPS];

	always_ff @(posedge clk) begin
		rt_rem_s[0]  <= '0;
		rt_root_s[0] <= '0;
		rt_val_s[0]  <= total[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_ctl_s[0] <= '0;
		end else begin
			rt_ctl_s[0] <= '{valid: ctl_s2.valid, sat: |total[66:64], plat: 1'b0, neg: 1'b0};
		end
	end

	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
		logic [34:0] cand;
		logic [34:0] trial;
		logic        ge;

		assign cand  = {rt_rem_s[j][32:0], rt_val_s[j][63:62]};
		assign trial = {1'b0, rt_root_s[j], 2'b01};
		assign ge    = (cand >= trial);

		always_ff @(posedge clk) begin
			rt_rem_s[j+1]  <= ge ? (cand - trial) : cand;
			rt_root_s[j+1] <= {rt_root_s[j][30:0], ge};
			rt_val_s[j+1]  <= {rt_val_s[j][61:0], 2'b00};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_ctl_s[j+1] <= '0;
			end else begin
				rt_ctl_s[j+1] <= rt_ctl_s[j];
			end
		end
	end

	// ---- rate stage: threshold, normalize, divider setup
	logic [31:0] rate;
	logic [4:0]  top;
	logic [31:0] norm;

	assign rate = rt_ctl_s[ROOT_STEPS].sat ? '1 : rt_root_s[ROOT_STEPS];

	always_comb begin
		top = '0;
		for (int i = 1; i < 32; i++) begin
			if (rate[i]) begin
				top = 5'(i);
			end
		end
	end

	assign norm = rate << (5'd31 - top);

	ctl_t        ctl_s   [0:T_STG];
	logic [31:0] dv_rem_s[0:T_STG];
	logic [47:0] dv_q_s  [0:T_STG];
	logic [31:0] dv_d_s  [0:T_STG];
	logic [31:0] lg_m_s    [0:LG_END];
	logic [4:0]  lg_p_s    [0:LG_END];
	logic [23:0] lg_frac_s [0:LG_END];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0] <= '{
				valid: rt_ctl_s[ROOT_STEPS].valid,
				sat:   rt_ctl_s[ROOT_STEPS].sat,
				plat:  (rate <= {1'b0, crit_q}),
				neg:   yield_q[31]
			};
		end
	end

	always_ff @(posedge clk) begin
		dv_rem_s[0]  <= '0;
		dv_q_s[0]    <= {abs32(yield_q), {FRAC_BITS{1'b0}}};
		dv_d_s[0]    <= rate;
		lg_m_s[0]    <= norm;
		lg_p_s[0]    <= top;
		lg_frac_s[0] <= '0;
	end

	for (genvar k = 1; k <= T_STG; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	// ---- restoring divider for |yield_offset| / rate
	for (genvar k = 1; k <= T_STG; k++) begin : g_div
		if (k <= DIV_BITS) begin : g_step
			logic [32:0] cand;
			logic [32:0] diff;
			logic        ge;

			assign cand = {dv_rem_s[k-1], dv_q_s[k-1][47]};
			assign ge   = (cand >= {1'b0, dv_d_s[k-1]});
			assign diff = cand - {1'b0, dv_d_s[k-1]};

			always_ff @(posedge clk) begin
				dv_rem_s[k] <= ge ? diff[31:0] : cand[31:0];
				dv_q_s[k]   <= {dv_q_s[k-1][46:0], ge};
				dv_d_s[k]   <= dv_d_s[k-1];
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				dv_rem_s[k] <= dv_rem_s[k-1];
				dv_q_s[k]   <= dv_q_s[k-1];
				dv_d_s[k]   <= dv_d_s[k-1];
			end
		end
	end

	// ---- log2 by repeated squaring
	for (genvar k = 1; k <= LG_END; k++) begin : g_log
		logic [63:0] sq;
		logic [32:0] sh;

		assign sq = lg_m_s[k-1] * lg_m_s[k-1];
		assign sh = sq[63:31];

		always_ff @(posedge clk) begin
			lg_m_s[k]    <= sh[32] ? sh[32:1] : sh[31:0];
			lg_p_s[k]    <= lg_p_s[k-1];
			lg_frac_s[k] <= {lg_frac_s[k-1][22:0], sh[32]};
		end
	end

	// ---- exponent (n - 1) * log2(rate)
	logic signed [21:0] e_w;
	logic [5:0]         lg_int;
	logic signed [29:0] lg_w;
	logic signed [51:0] prod_s;

	assign e_w    = $signed({flow_q[20], flow_q}) - 22'sd65536;
	assign lg_int = {1'b0, lg_p_s[LG_END]} - 6'(RATE_INT);
	assign lg_w   = $signed({lg_int, lg_frac_s[LG_END]});

	always_ff @(posedge clk) begin
		prod_s <= e_w * lg_w;
	end

	logic signed [51:0] ex_w;
	logic signed [51:0] tt_w;
	logic signed [13:0] x_q_s [XT_STG:X_END];
	logic [23:0]        x_f_s [XT_STG:X_END];
	logic [31:0]        x_m_s [XT_STG:X_END];

	assign ex_w = prod_s >>> FRAC_BITS;
	assign tt_w = ex_w + (52'sd1 <<< (LOG_FRAC + 4));

	always_ff @(posedge clk) begin
		x_q_s[XT_STG] <= tt_w[37:24];
		x_f_s[XT_STG] <= tt_w[23:0];
		x_m_s[XT_STG] <= 32'd1 << 31;
	end

	// ---- exp2 of the fraction, one coefficient per stage
	for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_exp
		localparam logic [31:0] COEF = exp_coef(i);
		logic [63:0] pr;

		assign pr = x_m_s[XT_STG+i-1] * COEF;

		always_ff @(posedge clk) begin
			x_m_s[XT_STG+i] <= x_f_s[XT_STG+i-1][LOG_FRAC-i] ? pr[62:31]
				: x_m_s[XT_STG+i-1];
			x_q_s[XT_STG+i] <= x_q_s[XT_STG+i-1];
			x_f_s[XT_STG+i] <= x_f_s[XT_STG+i-1];
		end
	end

	// ---- k term
	logic [62:0]        km_s;
	logic signed [13:0] sh_s;

	always_ff @(posedge clk) begin
		km_s <= coef_q * x_m_s[X_END];
		sh_s <= x_q_s[X_END] - 14'(KM_SHIFT);
	end

	logic [123:0] wide;
	logic [13:0]  nsh;
	logic [62:0]  term1;
	logic [62:0]  term1_s;

	assign wide = {61'd0, km_s} << sh_s[5:0];
	assign nsh  = 14'(-sh_s);

	always_comb begin
		if (km_s == '0) begin
			term1 = '0;
		end else if (!sh_s[13]) begin
			if (sh_s > 14'sd60 || wide > {61'd0, TERM_CAP}) begin
				term1 = TERM_CAP;
			end else begin
				term1 = wide[62:0];
			end
		end else if (nsh >= 14'd63) begin
			term1 = '0;
		end else begin
			term1 = km_s >> nsh[5:0];
		end
	end

	always_ff @(posedge clk) begin
		term1_s <= term1;
	end

	// ---- sum, clamp, select
	logic [47:0]        quot;
	logic signed [48:0] term2;
	logic signed [64:0] sum;
	logic               hi_clamp;
	logic               lo_clamp;
	ctl_t               fin;

	assign fin      = ctl_s[T_STG];
	assign quot     = dv_q_s[T_STG];
	assign term2    = fin.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
	assign sum      = $signed({2'b00, term1_s}) + 65'(term2);
	assign hi_clamp = (sum > 65'sd2147483647);
	assign lo_clamp = (sum < -65'sd2147483648);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!pmode_q) begin
			particle_viscosity <= {1'b0, plateau_q};
			saturated          <= 1'b0;
		end else if (fin.plat) begin
			particle_viscosity <= {1'b0, plateau_q};
			saturated          <= fin.sat;
		end else if (hi_clamp) begin
			particle_viscosity <= 32'sh7FFFFFFF;
			saturated          <= 1'b1;
		end else if (lo_clamp) begin
			particle_viscosity <= 32'sh80000000;
			saturated          <= 1'b1;
		end else begin
			particle_viscosity <= sum[31:0];
			saturated          <= fin.sat;
		end
	end

`ifndef SYNTHESIS
	a_const_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !pmode_q) |-> (particle_viscosity == {1'b0, plateau_q} && !saturated))
		else $error("constant mode result mismatch");
	a_ovf_not_plat: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s[0].valid && ctl_s[0].sat) |-> !ctl_s[0].plat)
		else $error("clamped rate treated as plateau");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(fin.valid && dv_d_s[T_STG] != '0) |-> (dv_rem_s[T_STG] < dv_d_s[T_STG]))
		else $error("divider remainder out of range");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(fin.valid))
		else $error("result strobe without item");
`endif

endmodule
